// File: sv/psvt_pkg.sv
// psvt_pkg: types, constants and helpers for the priority sorted vector table
// shared by the slot cell and the top level; depends on nothing else

package psvt_pkg;

   // slot count and derived widths
   localparam int SLOTS     = 16;
   localparam int SLOT_W    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int SRC_W     = 5;
   localparam int ADDR_W    = 32;
   localparam int PRIO_W    = 8;
   localparam int OUT_IDX_W = 4;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [SRC_W:0]    SRC_LIMIT = (SRC_W + 1)'(SLOTS);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITY_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_ADDR    = 1'b1;

   localparam logic [PRIO_W-1:0] PRIO_MASK_RESET  = 8'hFF;
   localparam logic [ADDR_W-1:0] EMPTY_ADDR_RESET = 32'h0000_0000;

   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UNREGISTER = 2'd1,
      CMD_CLEAR      = 2'd2,
      CMD_UNDEFINED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_REJECTED  = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_PLACE,
      S_EMIT
   } state_type;

   // what a cell loads at the next edge
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_TAKE_RIGHT,
      CELL_TAKE_LEFT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cmd_type             command;
      logic [SRC_W-1:0]    source_id;
      logic [ADDR_W-1:0]   handler_address;
      logic [PRIO_W-1:0]   priority_req;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                slot_write;
      logic [OUT_IDX_W-1:0] slot_index;
      logic                slot_enabled;
      logic [SRC_W-1:0]    slot_source;
      logic [ADDR_W-1:0]   slot_address;
      logic [OUT_IDX_W-1:0] final_position;
      logic                last;
   } rsp_type;

   // one slot of the table
   typedef struct packed {
      logic                used;
      logic [SRC_W-1:0]    source;
      logic [ADDR_W-1:0]   address;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   // search key broadcast to every cell
   typedef struct packed {
      logic [SRC_W-1:0]    source;
      logic [PRIO_W-1:0]   prio;
   } key_type;

   // per-cell compare results
   typedef struct packed {
      logic match;
      logic ge;
   } cell_flags_type;

   localparam entry_type EMPTY_ENTRY = entry_type'('0);

   // low four bits of a slot number, zero extended when the table is small
   function automatic logic [OUT_IDX_W-1:0] out_index(input logic [SLOT_W-1:0] v);
      logic [SLOT_W+OUT_IDX_W-1:0] w;
      w = {{OUT_IDX_W{1'b0}}, v};
      return w[OUT_IDX_W-1:0];
   endfunction

endpackage

// File: sv/priority_sorted_vector_table_top.sv
// priority_sorted_vector_table_top: controller and row of slot cells
// depends on psvt_pkg and psvt_cell
//
// a rejected or unknown-source command gives its single beat from the find state;
// unregister and clear go from find to emit, register from find through place to
// emit, which gives one beat per cycle with no gaps up to the last slot of the walk;
// start is taken only in idle, so the slot walk through the output mux decides when
// the next command can be taken; a clear walks every slot; the receiver cannot stall
// the beats
// reset: synchronous, every slot empty, mask 0xff, empty-slot address zero

module priority_sorted_vector_table_top import psvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [PRIO_W-1:0] prio_mask_ff;
   logic [ADDR_W-1:0] empty_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_mask_ff  <= PRIO_MASK_RESET;
         empty_addr_ff <= EMPTY_ADDR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRIORITY_MASK: prio_mask_ff  <= csr_wdata[PRIO_W-1:0];
            CSR_EMPTY_ADDR:    empty_addr_ff <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // control registers
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] k_ff, k_in;       // old position, or first empty slot
   logic [SLOT_W-1:0] idx_ff, idx_in;   // slot being emitted
   logic [SLOT_W-1:0] hi_ff, hi_in;     // last slot to emit
   logic [SLOT_W-1:0] fpos_ff, fpos_in; // final position of the source
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // row of cells
   cell_op_type       cell_op    [SLOTS];
   entry_type         cell_q     [SLOTS];
   entry_type         cell_left  [SLOTS];
   entry_type         cell_right [SLOTS];
   cell_flags_type    cell_flags [SLOTS];
   entry_type         new_entry;
   key_type           key;

   assign key.source = req_ff.source_id;
   assign key.prio   = req_ff.priority_req;

   assign new_entry.used    = 1'b1;
   assign new_entry.source  = req_ff.source_id;
   assign new_entry.address = req_ff.handler_address;
   assign new_entry.prio    = req_ff.priority_req;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      // neighbour wiring; the ends see an empty slot
      if (i == 0) begin : g_first
         assign cell_left[i] = EMPTY_ENTRY;
      end else begin : g_mid_left
         assign cell_left[i] = cell_q[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
         assign cell_right[i] = EMPTY_ENTRY;
      end else begin : g_mid_right
         assign cell_right[i] = cell_q[i+1];
      end

      psvt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (cell_op[i]),
         .left_q  (cell_left[i]),
         .right_q (cell_right[i]),
         .new_q   (new_entry),
         .key     (key),
         .q       (cell_q[i]),
         .flags   (cell_flags[i])
      );
   end

   // search over the cell flags: first match, first empty, first empty or lower priority
   logic              found;
   logic [SLOT_W-1:0] k_find;
   logic              has_empty;
   logic [SLOT_W-1:0] count_n;
   logic [SLOT_W-1:0] p_pos;
   logic              cmd_bad;
   logic              emit_last;
   logic [SLOT_W-1:0] lo_place;
   logic [SLOT_W-1:0] hi_place;
   entry_type         emit_entry;

   always_comb begin
      found     = 1'b0;
      k_find    = '0;
      has_empty = 1'b0;
      count_n   = '0;
      p_pos     = '0;
      // walk down so the lowest slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (cell_flags[i].match) begin
            found  = 1'b1;
            k_find = SLOT_W'(i);
         end
         if (!cell_q[i].used) begin
            has_empty = 1'b1;
            count_n   = SLOT_W'(i);
         end
         if (!cell_flags[i].ge) begin
            p_pos = SLOT_W'(i);
         end
      end
   end

   // bad source, zero handler on register, or an undefined command
   assign cmd_bad = (req_ff.command == CMD_UNDEFINED) ||
                    ({1'b0, req_ff.source_id} >= SRC_LIMIT) ||
                    ((req_ff.command == CMD_REGISTER) && (req_ff.handler_address == '0));

   assign emit_last  = (idx_ff == hi_ff);
   assign emit_entry = cell_q[idx_ff];
   assign lo_place   = (k_ff < p_pos) ? k_ff : p_pos;
   assign hi_place   = (k_ff < p_pos) ? p_pos : k_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (req_ff.command == CMD_CLEAR) begin
               state_in = S_EMIT;
            end else if (cmd_bad) begin
               state_in = S_IDLE;
            end else if (req_ff.command == CMD_UNREGISTER) begin
               state_in = found ? S_EMIT : S_IDLE;
            end else begin
               state_in = (found || has_empty) ? S_PLACE : S_IDLE;
            end
         end
         S_PLACE: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control and result beats
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cell_op[i] = CELL_HOLD;
      end
      req_in       = req_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      fpos_in      = fpos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in              = req_data;
               req_in.priority_req = req_data.priority_req & prio_mask_ff;
            end
         end
         S_FIND: begin
            if (req_ff.command == CMD_CLEAR) begin
               for (int i = 0; i < SLOTS; i++) begin
                  cell_op[i] = CELL_CLEAR;
               end
               idx_in  = '0;
               hi_in   = LAST_SLOT;
               fpos_in = '0;
            end else if (cmd_bad) begin
               rsp_in        = '0;
               rsp_in.status = ST_REJECTED;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
            end else if (req_ff.command == CMD_UNREGISTER) begin
               if (!found) begin
                  rsp_in        = '0;
                  rsp_in.status = ST_NOT_FOUND;
                  rsp_in.last   = 1'b1;
                  rsp_valid_in  = 1'b1;
               end else begin
                  // close the gap, the last slot takes an empty entry
                  for (int i = 0; i < SLOTS; i++) begin
                     if (SLOT_W'(i) >= k_find) begin
                        cell_op[i] = CELL_TAKE_RIGHT;
                     end
                  end
                  idx_in  = k_find;
                  hi_in   = LAST_SLOT;
                  fpos_in = '0;
               end
            end else begin
               if (!found && !has_empty) begin
                  // table full and a new source
                  rsp_in        = '0;
                  rsp_in.status = ST_REJECTED;
                  rsp_in.last   = 1'b1;
                  rsp_valid_in  = 1'b1;
               end else begin
                  if (found) begin
                     // pull the old entry out before placing it again
                     for (int i = 0; i < SLOTS; i++) begin
                        if (SLOT_W'(i) >= k_find) begin
                           cell_op[i] = CELL_TAKE_RIGHT;
                        end
                     end
                  end
                  k_in = found ? k_find : count_n;
               end
            end
         end
         S_PLACE: begin
            // open a hole after all entries of equal or higher priority
            for (int i = 0; i < SLOTS; i++) begin
               if (SLOT_W'(i) > p_pos) begin
                  cell_op[i] = CELL_TAKE_LEFT;
               end else if (SLOT_W'(i) == p_pos) begin
                  cell_op[i] = CELL_LOAD;
               end
            end
            idx_in  = lo_place;
            hi_in   = hi_place;
            fpos_in = p_pos;
         end
         S_EMIT: begin
            rsp_in.status         = ST_DONE;
            rsp_in.slot_write     = 1'b1;
            rsp_in.slot_index     = out_index(idx_ff);
            rsp_in.slot_enabled   = emit_entry.used;
            rsp_in.slot_source    = emit_entry.used ? emit_entry.source : '0;
            rsp_in.slot_address   = emit_entry.used ? emit_entry.address : empty_addr_ff;
            rsp_in.final_position = out_index(fpos_ff);
            rsp_in.last           = emit_last;
            rsp_valid_in          = 1'b1;
            if (!emit_last) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      fpos_ff <= fpos_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/psvt_cell.sv
// psvt_cell: one slot of the table, loads from its neighbours or a new entry
// depends on psvt_pkg

module psvt_cell import psvt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cell_op_type    op,
   input  entry_type      left_q,
   input  entry_type      right_q,
   input  entry_type      new_q,
   input  key_type        key,
   output entry_type      q,
   output cell_flags_type flags
);

   logic              used_ff;
   logic [SRC_W-1:0]  source_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [PRIO_W-1:0] prio_ff;
   entry_type         q_in;

   assign q = '{used: used_ff, source: source_ff, address: address_ff, prio: prio_ff};

   always_comb begin
      case (op)
         CELL_HOLD:       q_in = q;
         CELL_CLEAR:      q_in = EMPTY_ENTRY;
         CELL_TAKE_RIGHT: q_in = right_q;
         CELL_TAKE_LEFT:  q_in = left_q;
         CELL_LOAD:       q_in = new_q;
         default:         q_in = q;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= q_in.used;
      end
   end

   always_ff @(posedge clock) begin
      source_ff  <= q_in.source;
      address_ff <= q_in.address;
      prio_ff    <= q_in.prio;
   end

   // compares feeding the search encoders
   assign flags.match = used_ff && (source_ff == key.source);
   assign flags.ge    = used_ff && (prio_ff >= key.prio);

endmodule

// File: dv/psvt_slot_checker.sv
`timescale 1ns / 1ps
// psvt_slot_checker: keeps its own image of the vector slots and compares every result beat
// depends on psvt_pkg; watches the command, result and register ports of the table

module psvt_slot_checker import psvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  drain_check,
   output int                    fail_count,
   output int                    beats_due,
   output int                    beats_checked
);

   entry_type         image [SLOTS];
   logic [PRIO_W-1:0] mask_reg;
   logic [ADDR_W-1:0] empty_addr_reg;
   rsp_type           slot_writes_due [$];
   logic              drained;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic rsp_type slot_beat(input int idx, input int fpos, input logic is_last);
      rsp_type b;
      b                = '0;
      b.status         = ST_DONE;
      b.slot_write     = 1'b1;
      b.slot_index     = OUT_IDX_W'(idx);
      b.slot_enabled   = image[idx].used;
      b.slot_source    = image[idx].used ? image[idx].source : '0;
      b.slot_address   = image[idx].used ? image[idx].address : empty_addr_reg;
      b.final_position = OUT_IDX_W'(fpos);
      b.last           = is_last;
      return b;
   endfunction

   function automatic rsp_type status_beat(input status_type st);
      rsp_type b;
      b        = '0;
      b.status = st;
      b.last   = 1'b1;
      return b;
   endfunction

   task automatic queue_slot_range(input int lo, input int hi, input int fpos);
      for (int i = lo; i <= hi && i < SLOTS; i++) begin
         slot_writes_due.push_back(slot_beat(i, fpos, i == hi));
      end
   endtask

   // updates the slot image for one command and queues the beats it must cause
   task automatic replay_slot_update(input req_type r);
      logic [PRIO_W-1:0] prio;
      int                used_n;
      int                pos;
      int                dest;
      bit                hit;
      prio = r.priority_req & mask_reg;
      if (r.command == CMD_CLEAR) begin
         foreach (image[i]) image[i] = EMPTY_ENTRY;
         queue_slot_range(0, SLOTS - 1, 0);
         return;
      end
      if (r.command == CMD_UNDEFINED || r.source_id >= SLOTS ||
          (r.command == CMD_REGISTER && r.handler_address == '0)) begin
         slot_writes_due.push_back(status_beat(ST_REJECTED));
         return;
      end
      used_n = 0;
      while (used_n < SLOTS && image[used_n].used) used_n++;
      pos = used_n;
      hit = 1'b0;
      for (int i = 0; i < used_n; i++) begin
         if (!hit && image[i].source == r.source_id) begin
            pos = i;
            hit = 1'b1;
         end
      end
      if (r.command == CMD_UNREGISTER) begin
         if (!hit) begin
            slot_writes_due.push_back(status_beat(ST_NOT_FOUND));
            return;
         end
         for (int i = pos; i < SLOTS - 1; i++) image[i] = image[i + 1];
         image[SLOTS - 1] = EMPTY_ENTRY;
         queue_slot_range(pos, SLOTS - 1, 0);
         return;
      end
      if (!hit && used_n >= SLOTS) begin
         slot_writes_due.push_back(status_beat(ST_REJECTED));
         return;
      end
      // a move first takes the source out and closes the gap
      if (hit) begin
         for (int i = pos; i < used_n - 1; i++) image[i] = image[i + 1];
         used_n--;
         image[used_n] = EMPTY_ENTRY;
      end
      dest = 0;
      while (dest < used_n && image[dest].prio >= prio) dest++;
      for (int i = used_n; i > dest; i--) image[i] = image[i - 1];
      image[dest].used    = 1'b1;
      image[dest].source  = r.source_id;
      image[dest].address = r.handler_address;
      image[dest].prio    = prio;
      queue_slot_range(pos < dest ? pos : dest, pos < dest ? dest : pos, dest);
   endtask

   task automatic check_field(input string name, input int n,
                              input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h", n, name, got, want));
      end
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (slot_writes_due.size() == 0) begin
         report_mismatch($sformatf("beat with nothing due, slot %0d", got.slot_index));
         return;
      end
      want = slot_writes_due.pop_front();
      check_field("status", beats_checked, 32'(got.status), 32'(want.status));
      check_field("slot_write", beats_checked, 32'(got.slot_write), 32'(want.slot_write));
      check_field("slot_index", beats_checked, 32'(got.slot_index), 32'(want.slot_index));
      check_field("slot_enabled", beats_checked, 32'(got.slot_enabled),
                  32'(want.slot_enabled));
      check_field("slot_source", beats_checked, 32'(got.slot_source), 32'(want.slot_source));
      check_field("slot_address", beats_checked, got.slot_address, want.slot_address);
      check_field("final_position", beats_checked, 32'(got.final_position),
                  32'(want.final_position));
      check_field("last", beats_checked, 32'(got.last), 32'(want.last));
      beats_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (image[i]) image[i] = EMPTY_ENTRY;
         mask_reg       = PRIO_MASK_RESET;
         empty_addr_reg = EMPTY_ADDR_RESET;
         slot_writes_due.delete();
         drained        = 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PRIORITY_MASK) begin
               mask_reg = csr_wdata[PRIO_W-1:0];
            end else if (csr_index == CSR_EMPTY_ADDR) begin
               empty_addr_reg = csr_wdata[ADDR_W-1:0];
            end
         end
         if (rsp_valid) begin
            check_beat(rsp_data);
         end
         if (start && !busy) begin
            replay_slot_update(req_data);
         end
         if (drain_check && !drained) begin
            drained = 1'b1;
            if (slot_writes_due.size() != 0) begin
               report_mismatch($sformatf("%0d beats never arrived", slot_writes_due.size()));
            end
         end
      end
      beats_due = slot_writes_due.size();
   end

endmodule

// File: dv/priority_sorted_vector_table_top_tb.sv
`timescale 1ns / 1ps
// priority_sorted_vector_table_top_tb: command stimulus, register settings and verdict
// depends on psvt_pkg, priority_sorted_vector_table_top and psvt_slot_checker

module priority_sorted_vector_table_top_tb;
   import psvt_pkg::*;

   // cycles with no beat of any kind before the run is called hung;
   // a clear walks every slot, the long tail is the sender's idle streaks
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_CMDS  = 124;
   localparam int QUIET_PAUSE = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PRIORITY_MASK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  drain_check = 1'b0;

   int fail_count;
   int beats_due;
   int beats_checked;
   int cmds_sent;
   int directed_cmds;
   int settings_used;
   int idle_pct;
   int stall_cycles;

   always #5 clock = ~clock;

   priority_sorted_vector_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   psvt_slot_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .drain_check   (drain_check),
      .fail_count    (fail_count),
      .beats_due     (beats_due),
      .beats_checked (beats_checked)
   );

   // watchdog: any accepted command, result beat or register write restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles with no beat", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic req_type make_cmd(input cmd_type c, input int src,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [PRIO_W-1:0] prio);
      req_type r;
      r.command         = c;
      r.source_id       = SRC_W'(src);
      r.handler_address = addr;
      r.priority_req    = prio;
      return r;
   endfunction

   // mostly well-formed register/unregister traffic on valid sources, with a
   // few clears and some noise (bad sources, zero handler, undefined command)
   function automatic req_type random_cmd();
      req_type r;
      int      roll;
      roll              = $urandom_range(0, 99);
      r.source_id       = SRC_W'($urandom_range(0, SLOTS - 1));
      r.handler_address = $urandom();
      // a handful of shared levels so ties happen often
      case ($urandom_range(0, 7))
         0:       r.priority_req = 8'h00;
         1:       r.priority_req = 8'hFF;
         2:       r.priority_req = 8'h80;
         3:       r.priority_req = 8'h3C;
         default: r.priority_req = PRIO_W'($urandom());
      endcase
      if (roll < 56) begin
         r.command = CMD_REGISTER;
      end else if (roll < 81) begin
         r.command = CMD_UNREGISTER;
      end else if (roll < 85) begin
         r.command = CMD_CLEAR;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               r.command   = CMD_REGISTER;
               r.source_id = SRC_W'($urandom_range(SLOTS, 31));
            end
            1: begin
               r.command         = CMD_REGISTER;
               r.handler_address = '0;
            end
            2: begin
               r.command   = CMD_UNDEFINED;
               r.source_id = SRC_W'($urandom());
            end
            default: begin
               r.command   = CMD_UNREGISTER;
               r.source_id = SRC_W'($urandom_range(SLOTS, 31));
            end
         endcase
      end
      return r;
   endfunction

   // one command beat: optional idle gap, then hold start until busy is low at an edge
   task automatic send_cmd(input req_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      cmds_sent++;
   endtask

   // table idle: start dropped, nothing due, then a short pause for the tail
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (beats_due != 0 || busy) @(negedge clock);
      repeat (QUIET_PAUSE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_quiet();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic apply_setting(input logic [PRIO_W-1:0] mask, input logic [ADDR_W-1:0] empty);
      write_csr(CSR_PRIORITY_MASK, CSR_DATA_W'(mask));
      write_csr(CSR_EMPTY_ADDR, CSR_DATA_W'(empty));
      settings_used++;
   endtask

   initial begin
      idle_pct = 10;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed part: full mask, a recognisable empty-slot address
      apply_setting(8'hFF, 32'hA5A5_5A5A);
      send_cmd(make_cmd(CMD_UNREGISTER, 3, 32'h0000_1000, 8'h10));  // unknown source
      send_cmd(make_cmd(CMD_REGISTER, 16, 32'h0000_0001, 8'h10));   // source just past the table
      send_cmd(make_cmd(CMD_REGISTER, 31, 32'hFFFF_FFFF, 8'hFF));   // top source number
      send_cmd(make_cmd(CMD_REGISTER, 2, 32'h0000_0000, 8'h40));    // zero handler
      send_cmd(make_cmd(CMD_UNDEFINED, 0, 32'h0000_0040, 8'h00));   // undefined command
      send_cmd(make_cmd(CMD_UNREGISTER, 31, 32'h0000_0000, 8'h00)); // bad unregister source
      send_cmd(make_cmd(CMD_REGISTER, 0, 32'hFFFF_FFFF, 8'hFF));
      send_cmd(make_cmd(CMD_REGISTER, 15, 32'h0000_0001, 8'h00));
      send_cmd(make_cmd(CMD_REGISTER, 5, 32'h1234_5678, 8'h80));
      send_cmd(make_cmd(CMD_REGISTER, 7, 32'h8765_4321, 8'h80));    // tie lands behind
      send_cmd(make_cmd(CMD_REGISTER, 15, 32'h0000_0002, 8'hFF));   // move towards the front
      send_cmd(make_cmd(CMD_REGISTER, 0, 32'hFFFF_FFFE, 8'h00));    // move to the back
      send_cmd(make_cmd(CMD_REGISTER, 5, 32'h1234_5679, 8'h80));    // same level, re-queued
      send_cmd(make_cmd(CMD_UNREGISTER, 7, 32'h0, 8'h0));           // middle removal
      send_cmd(make_cmd(CMD_UNREGISTER, 0, 32'h0, 8'h0));           // last used slot
      send_cmd(make_cmd(CMD_CLEAR, 0, 32'h0, 8'h0));
      send_cmd(make_cmd(CMD_CLEAR, 31, 32'hFFFF_FFFF, 8'hFF));      // clear of an empty table
      send_cmd(make_cmd(CMD_REGISTER, 9, 32'h8000_0000, 8'h7F));
      send_cmd(make_cmd(CMD_UNREGISTER, 9, 32'h0, 8'h0));           // only entry, slot 0
      directed_cmds = cmds_sent;

      // random phases, each with its own register setting and idle profile
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               apply_setting(8'h00, 32'h0000_0000);   // every priority ties
               idle_pct = 19;
            end
            1: begin
               apply_setting(PRIO_W'($urandom()), $urandom());
               idle_pct = 78;
            end
            default: begin
               apply_setting(8'hF0, 32'hFFFF_FFFF);
               idle_pct = 0;   // back-to-back commands
            end
         endcase
         repeat (PHASE_CMDS) send_cmd(random_cmd());
      end

      // drain: nothing due, then a pause for any stray beat before the check
      wait_quiet();
      drain_check = 1'b1;
      @(negedge clock);
      @(negedge clock);

      $display("run: %0d commands (%0d directed), %0d result beats compared",
               cmds_sent, directed_cmds, beats_checked);
      $display("run: %0d mask/empty-address settings, idle 10/19/78/0 percent",
               settings_used);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/psvt_pkg.sv
sv/psvt_cell.sv
sv/priority_sorted_vector_table_top.sv
dv/psvt_slot_checker.sv
dv/priority_sorted_vector_table_top_tb.sv
